// File: hdl/deq_pkg.sv
package deq_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [2:0] {
    ACT_QUERY      = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_PUSH_BACK  = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_POP_BACK   = 3'd4
  } action_t;

  // broadcast to every cell of both chains
  // f chain holds the queue front first, b chain holds it back first
  typedef struct packed {
    logic f_push;
    logic f_pop;
    logic f_app;
    logic b_push;
    logic b_pop;
    logic b_app;
  } cell_cmd_t;

endpackage

// File: hdl/double_ended_queue.sv
// channel | direction | ports
// --------+-----------+------------------------------------------------------------
// in      | input     | in_valid, in_ready, in_action, in_value
// out     | output    | out_valid, out_ready, out_front_value, out_back_value,
//         |           | out_count, out_is_empty, out_rejected
//
// one item per cycle: each transfer updates two chains of DEPTH cells at once,
// every cell shifts from a neighbor or loads the value locally, and the result is
// presented in the next cycle from cell zero of each chain.
// reset leaves the queue empty with no result pending.
// while a result waits and out_ready is low, in_ready is low and the state holds.
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_action,
  input  logic signed [31:0]   in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_front_value,
  output logic signed [31:0]   out_back_value,
  output logic [4:0]           out_count,
  output logic                 out_is_empty,
  output logic                 out_rejected
);

  localparam int CW = $clog2(DEPTH + 1);

  logic               in_fire;
  logic               full;
  logic               empty;
  logic [CW-1:0]      count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               rejected_r, rejected_nxt;
  deq_pkg::cell_cmd_t cmd;
  deq_pkg::data_t     f_q [DEPTH];
  deq_pkg::data_t     b_q [DEPTH];
  logic [CW+4:0]      count_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);

  always_comb begin
    cmd          = '0;
    count_nxt    = count_r;
    rejected_nxt = 1'b0;
    case (in_action)
      deq_pkg::ACT_PUSH_FRONT: begin
        if (full) begin
          rejected_nxt = 1'b1;
        end else begin
          cmd.f_push = 1'b1;
          cmd.b_app  = 1'b1;
          count_nxt  = count_r + CW'(1);
        end
      end
      deq_pkg::ACT_PUSH_BACK: begin
        if (full) begin
          rejected_nxt = 1'b1;
        end else begin
          cmd.b_push = 1'b1;
          cmd.f_app  = 1'b1;
          count_nxt  = count_r + CW'(1);
        end
      end
      deq_pkg::ACT_POP_FRONT: begin
        if (empty) begin
          rejected_nxt = 1'b1;
        end else begin
          cmd.f_pop = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end
      deq_pkg::ACT_POP_BACK: begin
        if (empty) begin
          rejected_nxt = 1'b1;
        end else begin
          cmd.b_pop = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
      end
    endcase
    if (!in_fire) begin
      cmd          = '0;
      count_nxt    = count_r;
      rejected_nxt = rejected_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rejected_r  <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      rejected_r  <= rejected_nxt;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    deq_pkg::data_t f_prev, f_next, b_prev, b_next;

    if (g == 0) begin : g_first
      assign f_prev = in_value;
      assign b_prev = in_value;
    end else begin : g_mid
      assign f_prev = f_q[g-1];
      assign b_prev = b_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign f_next = f_q[g];
      assign b_next = b_q[g];
    end else begin : g_inner
      assign f_next = f_q[g+1];
      assign b_next = b_q[g+1];
    end

    deq_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk    (clk),
      .cmd    (cmd),
      .count  (count_r),
      .value  (in_value),
      .f_prev (f_prev),
      .f_next (f_next),
      .b_prev (b_prev),
      .b_next (b_next),
      .f      (f_q[g]),
      .b      (b_q[g])
    );
  end

  assign count_ext       = {5'd0, count_r};
  assign out_valid       = out_valid_r;
  assign out_front_value = empty ? '1 : f_q[0];
  assign out_back_value  = empty ? '1 : b_q[0];
  assign out_count       = count_ext[4:0];
  assign out_is_empty    = empty;
  assign out_rejected    = rejected_r;

`ifndef NO_ASSERTIONS
  // both chains must agree when front and back are the same element
  a_single_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && count_r == CW'(1)) |-> (f_q[0] == b_q[0]))
    else $error("front and back chains disagree on a single element");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above depth");

  a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (!rejected_r || count_r == $past(count_r)))
    else $error("rejected transfer changed the count");

  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !full && (in_action == deq_pkg::ACT_PUSH_FRONT ||
                          in_action == deq_pkg::ACT_PUSH_BACK))
    |=> (count_r == $past(count_r) + CW'(1)))
    else $error("accepted push did not grow the queue");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(count_r))
    else $error("state moved while a result was stalled");
`endif

endmodule

// File: hdl/deq_cell.sv
module deq_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic               clk,
  input  deq_pkg::cell_cmd_t cmd,
  input  logic [CW-1:0]      count,
  input  deq_pkg::data_t     value,
  input  deq_pkg::data_t     f_prev,
  input  deq_pkg::data_t     f_next,
  input  deq_pkg::data_t     b_prev,
  input  deq_pkg::data_t     b_next,
  output deq_pkg::data_t     f,
  output deq_pkg::data_t     b
);

  deq_pkg::data_t f_r, f_nxt;
  deq_pkg::data_t b_r, b_nxt;
  logic           at_end;

  // this cell is the first free slot of the window
  assign at_end = (count == CW'(IDX));

  always_comb begin
    f_nxt = f_r;
    if (cmd.f_push) begin
      f_nxt = f_prev;
    end else if (cmd.f_pop) begin
      f_nxt = f_next;
    end else if (cmd.f_app && at_end) begin
      f_nxt = value;
    end
  end

  always_comb begin
    b_nxt = b_r;
    if (cmd.b_push) begin
      b_nxt = b_prev;
    end else if (cmd.b_pop) begin
      b_nxt = b_next;
    end else if (cmd.b_app && at_end) begin
      b_nxt = value;
    end
  end

  always_ff @(posedge clk) begin
    f_r <= f_nxt;
    b_r <= b_nxt;
  end

  assign f = f_r;
  assign b = b_r;

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS = 440;

  // action codes the block treats as a plain query
  localparam logic [2:0] ACT_SPARE_FIRST = 3'(deq_pkg::ACT_POP_BACK) + 3'd1;
  localparam logic [2:0] ACT_SPARE_LAST = '1;

  localparam deq_pkg::data_t DATA_MIN = {1'b1, {(deq_pkg::DATA_W-1){1'b0}}};
  localparam deq_pkg::data_t DATA_MAX = ~DATA_MIN;
  localparam deq_pkg::data_t DATA_ONES = '1;

  typedef enum int {TREND_FILL, TREND_DRAIN, TREND_MIXED} trend_t;

  typedef struct {
    deq_pkg::data_t front;
    deq_pkg::data_t back;
    logic [4:0]     count;
    logic           empty;
    logic           rejected;
  } deque_view_t;

  class deque_board;
    deq_pkg::data_t slots [QUEUE_DEPTH];
    int unsigned    head;
    int unsigned    fill;
    deque_view_t    pending_views [$];
    int unsigned    errors;

    function new();
      head = 0;
      fill = 0;
      errors = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function void note_action(logic [2:0] act, deq_pkg::data_t val);
      deque_view_t v;
      v.rejected = 1'b0;
      case (act)
        deq_pkg::ACT_PUSH_FRONT: begin
          if (fill >= QUEUE_DEPTH) begin
            v.rejected = 1'b1;
          end else begin
            head = (head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
            slots[head] = val;
            fill++;
          end
        end
        deq_pkg::ACT_PUSH_BACK: begin
          if (fill >= QUEUE_DEPTH) begin
            v.rejected = 1'b1;
          end else begin
            slots[(head + fill) % QUEUE_DEPTH] = val;
            fill++;
          end
        end
        deq_pkg::ACT_POP_FRONT: begin
          if (fill == 0) begin
            v.rejected = 1'b1;
          end else begin
            head = (head + 1) % QUEUE_DEPTH;
            fill--;
          end
        end
        deq_pkg::ACT_POP_BACK: begin
          if (fill == 0) v.rejected = 1'b1;
          else fill--;
        end
        default: ;
      endcase
      v.count = 5'(fill);
      v.empty = (fill == 0);
      v.front = v.empty ? DATA_ONES : slots[head];
      v.back = v.empty ? DATA_ONES : slots[(head + fill - 1) % QUEUE_DEPTH];
      pending_views = {pending_views, v};
    endfunction

    task report(string msg);
      $display("[tb] mismatch: %s", msg);
      errors++;
    endtask

    task check_view(deque_view_t got);
      deque_view_t want;
      if (pending_views.size() == 0) begin
        report($sformatf("result with nothing pending: front=%0d back=%0d count=%0d",
                         got.front, got.back, got.count));
        return;
      end
      want = pending_views[0];
      pending_views.delete(0);
      if (got.front !== want.front)
        report($sformatf("front_value got %0d want %0d", got.front, want.front));
      if (got.back !== want.back)
        report($sformatf("back_value got %0d want %0d", got.back, want.back));
      if (got.count !== want.count)
        report($sformatf("count got %0d want %0d", got.count, want.count));
      if (got.empty !== want.empty)
        report($sformatf("is_empty got %b want %b", got.empty, want.empty));
      if (got.rejected !== want.rejected)
        report($sformatf("rejected got %b want %b", got.rejected, want.rejected));
    endtask
  endclass

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [2:0]     in_action = deq_pkg::ACT_QUERY;
  deq_pkg::data_t in_value = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  deq_pkg::data_t out_front_value;
  deq_pkg::data_t out_back_value;
  logic [4:0]     out_count;
  logic           out_is_empty;
  logic           out_rejected;

  int             in_idle_pct = 0;
  int             out_stall_pct = 0;
  int             quiet_cycles = 0;
  deque_view_t    seen_view;

  deque_board board;

  double_ended_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_front_value(out_front_value),
    .out_back_value (out_back_value),
    .out_count      (out_count),
    .out_is_empty   (out_is_empty),
    .out_rejected   (out_rejected)
  );

  always #5 clk = ~clk;

  // result side: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_view.front = out_front_value;
      seen_view.back = out_back_value;
      seen_view.count = out_count;
      seen_view.empty = out_is_empty;
      seen_view.rejected = out_rejected;
      board.check_view(seen_view);
    end
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[double_ended_queue] ERROR");
      $finish;
    end
  end

  function automatic deq_pkg::data_t edge_value(int k);
    case (k % 5)
      0: return DATA_MIN;
      1: return DATA_MAX;
      2: return DATA_ONES;
      3: return '0;
      default: return deq_pkg::data_t'(1);
    endcase
  endfunction

  function automatic logic [2:0] pick_action(trend_t trend);
    int   r;
    int   push_pct;
    logic front_end;
    r = $urandom_range(0, 99);
    front_end = 1'($urandom_range(0, 1));
    if (r < 4) return 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    if (r < 9) return deq_pkg::ACT_QUERY;
    case (trend)
      TREND_FILL:  push_pct = 80;
      TREND_DRAIN: push_pct = 20;
      default:     push_pct = 50;
    endcase
    if ($urandom_range(0, 99) < push_pct)
      return front_end ? deq_pkg::ACT_PUSH_FRONT : deq_pkg::ACT_PUSH_BACK;
    return front_end ? deq_pkg::ACT_POP_FRONT : deq_pkg::ACT_POP_BACK;
  endfunction

  task automatic send_item(input logic [2:0] act, input deq_pkg::data_t val);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_value <= val;
    do @(posedge clk); while (in_ready !== 1'b1);
    board.note_action(act, val);
  endtask

  task automatic run_directed();
    send_item(deq_pkg::ACT_QUERY, DATA_MAX);
    send_item(deq_pkg::ACT_POP_FRONT, DATA_MIN);
    send_item(deq_pkg::ACT_POP_BACK, DATA_ONES);
    for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++) send_item(3'(a), $urandom);
    // fill from both ends so the window wraps below slot zero
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_item(i[0] ? deq_pkg::ACT_PUSH_BACK : deq_pkg::ACT_PUSH_FRONT, edge_value(i));
    send_item(deq_pkg::ACT_PUSH_FRONT, DATA_MAX);
    send_item(deq_pkg::ACT_PUSH_BACK, DATA_MIN);
    send_item(deq_pkg::ACT_POP_FRONT, '0);
    send_item(deq_pkg::ACT_POP_BACK, '0);
    send_item(deq_pkg::ACT_QUERY, '0);
  endtask

  task automatic run_random(int n, int idle_pct, int stall_pct);
    trend_t         trend;
    int             left_in_trend;
    deq_pkg::data_t val;
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    trend = TREND_MIXED;
    left_in_trend = 0;
    repeat (n) begin
      // runs of mostly pushes or mostly pops reach the full and empty states
      if (left_in_trend == 0) begin
        trend = trend_t'($urandom_range(TREND_FILL, TREND_MIXED));
        left_in_trend = $urandom_range(15, 60);
      end
      left_in_trend--;
      if ($urandom_range(0, 99) < 12) val = edge_value($urandom_range(0, 4));
      else val = $urandom;
      send_item(pick_action(trend), val);
    end
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random(PHASE_ITEMS, 0, 0);
    run_random(PHASE_ITEMS, 50, 0);
    run_random(PHASE_ITEMS, 0, 50);
    run_random(PHASE_ITEMS, 7, 7);
    in_valid <= 1'b0;
    while (board.pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("[double_ended_queue] OK");
    end else begin
      $display("[double_ended_queue] ERROR");
    end
    $finish;
  end

endmodule
